>>> rtl/tas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tas_pkg
// Shared types and constants for the two-axis arm sequencer: phase codes,
// command codes, register indexes, speed limits and tolerances in degrees.
// ---------------------------------------------------------------------------
package tas_pkg;

    // Arm phase codes.
    typedef enum logic [2:0] {
        PH_RECOVERING = 3'd0,
        PH_ACCEPTING  = 3'd1,
        PH_READY      = 3'd2,
        PH_SCORING    = 3'd3,
        PH_RELEASING  = 3'd4
    } phase_t;

    // Operator command codes; the unused code acts as no command.
    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_SCORE   = 2'd1;
    localparam logic [1:0] CMD_RECOVER = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_ACCEPT_LIFT   = 3'd0;
    localparam logic [2:0] REG_ACCEPT_WRIST  = 3'd1;
    localparam logic [2:0] REG_READY_WRIST   = 3'd2;
    localparam logic [2:0] REG_SCORE_LIFT    = 3'd3;
    localparam logic [2:0] REG_SCORE_WRIST   = 3'd4;
    localparam logic [2:0] REG_RELEASE_LIFT  = 3'd5;
    localparam logic [2:0] REG_RELEASE_WRIST = 3'd6;
    localparam logic [2:0] REG_DEFAULT_TOL   = 3'd7;

    // Register address width (eight 32-bit registers).
    localparam int ADDR_WIDTH = 5;
    localparam int TOL_WIDTH  = 16;

    // Reset values, 1/16 degree units.
    localparam int RST_ACCEPT_LIFT   = 7360;
    localparam int RST_ACCEPT_WRIST  = -2080;
    localparam int RST_READY_WRIST   = -800;
    localparam int RST_SCORE_LIFT    = 5440;
    localparam int RST_SCORE_WRIST   = 1600;
    localparam int RST_RELEASE_LIFT  = 10400;
    localparam int RST_RELEASE_WRIST = 1920;
    localparam logic [15:0] RST_DEFAULT_TOL = 16'd48;

    // Speed limits in rpm.
    localparam logic [7:0] LIFT_SPEED       = 8'd200;
    localparam logic [7:0] WRIST_SPEED_FAST = 8'd100;
    localparam logic [7:0] WRIST_SPEED_SLOW = 8'd70;

    // Phase tolerances and thresholds in whole degrees.
    localparam int TOL_READY_LIFT_DEG     = 50;
    localparam int TOL_READY_WRIST_DEG    = 30;
    localparam int TOL_SCORE_LIFT_DEG     = 6;
    localparam int TOL_RELEASE_LIFT_DEG   = 8;
    localparam int TOL_RELEASE_WRIST_DEG  = 15;
    localparam int RELEASE_WRIST_HIGH_DEG = 590;

endpackage
`default_nettype wire

>>> rtl/two_axis_arm_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one beat per cycle while the result channel is not stalled;
// input register, combinational compare and select logic, and a result
// register that holds a stalled result.
// Reset: phase is recovering, registers take their reset values, and both
// pipeline stages are empty.
// ---------------------------------------------------------------------------
// two_axis_arm_sequencer
// Five-phase arm sequencer for a lift and wrist axis. Each input beat is one
// control tick; each produces one result beat with phase, targets and speeds.
// ---------------------------------------------------------------------------
module two_axis_arm_sequencer #(
    parameter int FRAC_BITS = 4,
    parameter int POS_WIDTH = 18
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tas_pkg::ADDR_WIDTH-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    // Input channel.
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [POS_WIDTH-1:0]     lift_position,
    input  wire logic signed [POS_WIDTH-1:0]     wrist_position,
    input  wire logic [1:0]                      command,
    // Result channel.
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [2:0]                           phase,
    output logic signed [POS_WIDTH-1:0]          lift_target,
    output logic [7:0]                           lift_speed,
    output logic signed [POS_WIDTH-1:0]          wrist_target,
    output logic [7:0]                           wrist_speed
);

    logic signed [POS_WIDTH-1:0]   acc_lift;
    logic signed [POS_WIDTH-1:0]   acc_wrist;
    logic signed [POS_WIDTH-1:0]   rdy_wrist;
    logic signed [POS_WIDTH-1:0]   scr_lift;
    logic signed [POS_WIDTH-1:0]   scr_wrist;
    logic signed [POS_WIDTH-1:0]   rel_lift;
    logic signed [POS_WIDTH-1:0]   rel_wrist;
    logic [tas_pkg::TOL_WIDTH-1:0] dflt_tol;

    logic                          in_valid_reg;
    logic signed [POS_WIDTH-1:0]   lift_meas_reg;
    logic signed [POS_WIDTH-1:0]   wrist_meas_reg;
    logic [1:0]                    cmd_reg;
    tas_pkg::phase_t               arm_phase_reg;
    tas_pkg::phase_t               arm_phase_next;

    logic                          out_valid_reg;
    tas_pkg::phase_t               out_phase_reg;
    logic signed [POS_WIDTH-1:0]   lift_tgt_reg;
    logic signed [POS_WIDTH-1:0]   lift_tgt_next;
    logic [7:0]                    lift_spd_reg;
    logic [7:0]                    lift_spd_next;
    logic signed [POS_WIDTH-1:0]   wrist_tgt_reg;
    logic signed [POS_WIDTH-1:0]   wrist_tgt_next;
    logic [7:0]                    wrist_spd_reg;
    logic [7:0]                    wrist_spd_next;

    logic                          out_free;
    logic                          advance;
    logic                          in_take;

    tas_cfg_regs #(
        .POS_WIDTH (POS_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .acc_lift  (acc_lift),
        .acc_wrist (acc_wrist),
        .rdy_wrist (rdy_wrist),
        .scr_lift  (scr_lift),
        .scr_wrist (scr_wrist),
        .rel_lift  (rel_lift),
        .rel_wrist (rel_wrist),
        .dflt_tol  (dflt_tol)
    );

    tas_step #(
        .FRAC_BITS (FRAC_BITS),
        .POS_WIDTH (POS_WIDTH)
    ) u_step (
        .phase_in   (arm_phase_reg),
        .lift_meas  (lift_meas_reg),
        .wrist_meas (wrist_meas_reg),
        .cmd        (cmd_reg),
        .acc_lift   (acc_lift),
        .acc_wrist  (acc_wrist),
        .rdy_wrist  (rdy_wrist),
        .scr_lift   (scr_lift),
        .scr_wrist  (scr_wrist),
        .rel_lift   (rel_lift),
        .rel_wrist  (rel_wrist),
        .dflt_tol   (dflt_tol),
        .phase_out  (arm_phase_next),
        .lift_tgt   (lift_tgt_next),
        .lift_spd   (lift_spd_next),
        .wrist_tgt  (wrist_tgt_next),
        .wrist_spd  (wrist_spd_next)
    );

    // Pipeline flow: the result register frees when empty or when taken.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            lift_meas_reg  <= lift_position;
            wrist_meas_reg <= wrist_position;
            cmd_reg        <= command;
        end
    end

    // Phase state and result valid advance together with each beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_phase_reg <= tas_pkg::PH_RECOVERING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                arm_phase_reg <= arm_phase_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_phase_reg <= arm_phase_next;
            lift_tgt_reg  <= lift_tgt_next;
            lift_spd_reg  <= lift_spd_next;
            wrist_tgt_reg <= wrist_tgt_next;
            wrist_spd_reg <= wrist_spd_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign phase        = out_phase_reg;
    assign lift_target  = lift_tgt_reg;
    assign lift_speed   = lift_spd_reg;
    assign wrist_target = wrist_tgt_reg;
    assign wrist_speed  = wrist_spd_reg;

    // The held result always carries the current phase state.
    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_phase_reg == arm_phase_reg)
        else $error("result phase differs from phase state");

    // Input stalls only while a beat is waiting in the input register.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // A beat that moves forward lands in the result register.
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat lost");

    // A recover command in scoring or releasing always ends in recovering.
    a_recover_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == tas_pkg::CMD_RECOVER &&
         (arm_phase_reg == tas_pkg::PH_SCORING ||
          arm_phase_reg == tas_pkg::PH_RELEASING))
        |=> arm_phase_reg == tas_pkg::PH_RECOVERING)
        else $error("recover command ignored");

    // Phase state changes only when a beat moves forward.
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(arm_phase_reg))
        else $error("phase changed without a beat");

endmodule
`default_nettype wire

>>> rtl/tas_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tas_cfg_regs
// Configuration register file behind an APB-style port. Seven signed
// position targets and one unsigned default tolerance.
// ---------------------------------------------------------------------------
module tas_cfg_regs #(
    parameter int POS_WIDTH = 18
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tas_pkg::ADDR_WIDTH-1:0]    paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    output logic signed [POS_WIDTH-1:0]            acc_lift,
    output logic signed [POS_WIDTH-1:0]            acc_wrist,
    output logic signed [POS_WIDTH-1:0]            rdy_wrist,
    output logic signed [POS_WIDTH-1:0]            scr_lift,
    output logic signed [POS_WIDTH-1:0]            scr_wrist,
    output logic signed [POS_WIDTH-1:0]            rel_lift,
    output logic signed [POS_WIDTH-1:0]            rel_wrist,
    output logic [tas_pkg::TOL_WIDTH-1:0]          dflt_tol
);

    logic signed [POS_WIDTH-1:0]   acc_lift_reg;
    logic signed [POS_WIDTH-1:0]   acc_wrist_reg;
    logic signed [POS_WIDTH-1:0]   rdy_wrist_reg;
    logic signed [POS_WIDTH-1:0]   scr_lift_reg;
    logic signed [POS_WIDTH-1:0]   scr_wrist_reg;
    logic signed [POS_WIDTH-1:0]   rel_lift_reg;
    logic signed [POS_WIDTH-1:0]   rel_wrist_reg;
    logic [tas_pkg::TOL_WIDTH-1:0] dflt_tol_reg;
    logic                          wr_en;
    logic [2:0]                    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes on the access phase of a write beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_lift_reg  <= POS_WIDTH'(tas_pkg::RST_ACCEPT_LIFT);
            acc_wrist_reg <= POS_WIDTH'(tas_pkg::RST_ACCEPT_WRIST);
            rdy_wrist_reg <= POS_WIDTH'(tas_pkg::RST_READY_WRIST);
            scr_lift_reg  <= POS_WIDTH'(tas_pkg::RST_SCORE_LIFT);
            scr_wrist_reg <= POS_WIDTH'(tas_pkg::RST_SCORE_WRIST);
            rel_lift_reg  <= POS_WIDTH'(tas_pkg::RST_RELEASE_LIFT);
            rel_wrist_reg <= POS_WIDTH'(tas_pkg::RST_RELEASE_WRIST);
            dflt_tol_reg  <= tas_pkg::RST_DEFAULT_TOL;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                tas_pkg::REG_ACCEPT_LIFT:   acc_lift_reg  <= pwdata[POS_WIDTH-1:0];
                tas_pkg::REG_ACCEPT_WRIST:  acc_wrist_reg <= pwdata[POS_WIDTH-1:0];
                tas_pkg::REG_READY_WRIST:   rdy_wrist_reg <= pwdata[POS_WIDTH-1:0];
                tas_pkg::REG_SCORE_LIFT:    scr_lift_reg  <= pwdata[POS_WIDTH-1:0];
                tas_pkg::REG_SCORE_WRIST:   scr_wrist_reg <= pwdata[POS_WIDTH-1:0];
                tas_pkg::REG_RELEASE_LIFT:  rel_lift_reg  <= pwdata[POS_WIDTH-1:0];
                tas_pkg::REG_RELEASE_WRIST: rel_wrist_reg <= pwdata[POS_WIDTH-1:0];
                tas_pkg::REG_DEFAULT_TOL:   dflt_tol_reg  <= pwdata[tas_pkg::TOL_WIDTH-1:0];
                default:                    dflt_tol_reg  <= dflt_tol_reg;
            endcase
        end
    end

    // Read mux; position targets read back sign-extended.
    always_comb
    begin
        unique case (reg_idx)
            tas_pkg::REG_ACCEPT_LIFT:   prdata = 32'(acc_lift_reg);
            tas_pkg::REG_ACCEPT_WRIST:  prdata = 32'(acc_wrist_reg);
            tas_pkg::REG_READY_WRIST:   prdata = 32'(rdy_wrist_reg);
            tas_pkg::REG_SCORE_LIFT:    prdata = 32'(scr_lift_reg);
            tas_pkg::REG_SCORE_WRIST:   prdata = 32'(scr_wrist_reg);
            tas_pkg::REG_RELEASE_LIFT:  prdata = 32'(rel_lift_reg);
            tas_pkg::REG_RELEASE_WRIST: prdata = 32'(rel_wrist_reg);
            tas_pkg::REG_DEFAULT_TOL:   prdata = 32'(dflt_tol_reg);
            default:                    prdata = '0;
        endcase
    end

    assign acc_lift  = acc_lift_reg;
    assign acc_wrist = acc_wrist_reg;
    assign rdy_wrist = rdy_wrist_reg;
    assign scr_lift  = scr_lift_reg;
    assign scr_wrist = scr_wrist_reg;
    assign rel_lift  = rel_lift_reg;
    assign rel_wrist = rel_wrist_reg;
    assign dflt_tol  = dflt_tol_reg;

endmodule
`default_nettype wire

>>> rtl/tas_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tas_step
// One control tick: chains the phase transitions in fixed order and
// selects the targets and speed limits of the resulting phase.
// ---------------------------------------------------------------------------
module tas_step #(
    parameter int FRAC_BITS = 4,
    parameter int POS_WIDTH = 18
) (
    input  wire tas_pkg::phase_t                phase_in,
    input  wire logic signed [POS_WIDTH-1:0]    lift_meas,
    input  wire logic signed [POS_WIDTH-1:0]    wrist_meas,
    input  wire logic [1:0]                     cmd,
    input  wire logic signed [POS_WIDTH-1:0]    acc_lift,
    input  wire logic signed [POS_WIDTH-1:0]    acc_wrist,
    input  wire logic signed [POS_WIDTH-1:0]    rdy_wrist,
    input  wire logic signed [POS_WIDTH-1:0]    scr_lift,
    input  wire logic signed [POS_WIDTH-1:0]    scr_wrist,
    input  wire logic signed [POS_WIDTH-1:0]    rel_lift,
    input  wire logic signed [POS_WIDTH-1:0]    rel_wrist,
    input  wire logic [tas_pkg::TOL_WIDTH-1:0]  dflt_tol,
    output tas_pkg::phase_t                     phase_out,
    output logic signed [POS_WIDTH-1:0]         lift_tgt,
    output logic [7:0]                          lift_spd,
    output logic signed [POS_WIDTH-1:0]         wrist_tgt,
    output logic [7:0]                          wrist_spd
);

    // Compare width: holds a position difference, the tolerance and the
    // scaled release threshold with a sign bit to spare.
    localparam int BASE_W = (POS_WIDTH + 1 > 10 + FRAC_BITS) ? POS_WIDTH + 1 : 10 + FRAC_BITS;
    localparam int CW     = (BASE_W > tas_pkg::TOL_WIDTH ? BASE_W : tas_pkg::TOL_WIDTH) + 2;
    localparam int SCALE  = 2 ** FRAC_BITS;

    localparam logic signed [CW-1:0] TOL_RDY_L  = CW'(tas_pkg::TOL_READY_LIFT_DEG * SCALE);
    localparam logic signed [CW-1:0] TOL_RDY_W  = CW'(tas_pkg::TOL_READY_WRIST_DEG * SCALE);
    localparam logic signed [CW-1:0] TOL_SCR_L  = CW'(tas_pkg::TOL_SCORE_LIFT_DEG * SCALE);
    localparam logic signed [CW-1:0] TOL_REL_L  = CW'(tas_pkg::TOL_RELEASE_LIFT_DEG * SCALE);
    localparam logic signed [CW-1:0] TOL_REL_W  = CW'(tas_pkg::TOL_RELEASE_WRIST_DEG * SCALE);
    localparam logic signed [CW-1:0] WRIST_HIGH = CW'(tas_pkg::RELEASE_WRIST_HIGH_DEG * SCALE);

    // True when |pos - tgt| is strictly below the tolerance.
    function automatic logic near(input logic signed [CW-1:0] pos,
                                  input logic signed [CW-1:0] tgt,
                                  input logic signed [CW-1:0] tol);
        logic signed [CW-1:0] d;
        d = pos - tgt;
        if (d < 0)
        begin
            d = -d;
        end
        return d < tol;
    endfunction

    logic signed [CW-1:0] lp;
    logic signed [CW-1:0] wp;
    logic signed [CW-1:0] acc_l;
    logic signed [CW-1:0] acc_w;
    logic signed [CW-1:0] rdy_w;
    logic signed [CW-1:0] scr_l;
    logic signed [CW-1:0] scr_w;
    logic signed [CW-1:0] rel_l;
    logic signed [CW-1:0] dtol;
    logic                 near_rec;
    logic                 near_rdy;
    logic                 near_scr;
    logic                 near_rel;
    tas_pkg::phase_t      ph_a;
    tas_pkg::phase_t      ph_b;
    tas_pkg::phase_t      ph_c;
    tas_pkg::phase_t      ph_d;

    // Widen everything to the compare width.
    assign lp    = CW'(lift_meas);
    assign wp    = CW'(wrist_meas);
    assign acc_l = CW'(acc_lift);
    assign acc_w = CW'(acc_wrist);
    assign rdy_w = CW'(rdy_wrist);
    assign scr_l = CW'(scr_lift);
    assign scr_w = CW'(scr_wrist);
    assign rel_l = CW'(rel_lift);
    assign dtol  = CW'(dflt_tol);

    // Per-phase arrival checks, all in parallel.
    assign near_rec = near(lp, acc_l, dtol) && near(wp, acc_w, dtol);
    assign near_rdy = near(lp, acc_l, TOL_RDY_L) && near(wp, rdy_w, TOL_RDY_W);
    assign near_scr = near(lp, scr_l, TOL_SCR_L) && near(wp, scr_w, dtol);
    assign near_rel = near(lp, rel_l, TOL_REL_L) && near(wp, scr_w, TOL_REL_W);

    // Transition chain in fixed order; each check sees the previous result.
    always_comb
    begin
        ph_a = phase_in;
        if (phase_in == tas_pkg::PH_RECOVERING && near_rec)
        begin
            ph_a = tas_pkg::PH_ACCEPTING;
        end
        ph_b = ph_a;
        if (ph_a == tas_pkg::PH_ACCEPTING && cmd == tas_pkg::CMD_SCORE)
        begin
            ph_b = tas_pkg::PH_READY;
        end
        ph_c = ph_b;
        if (ph_b == tas_pkg::PH_READY && near_rdy)
        begin
            ph_c = tas_pkg::PH_SCORING;
        end
        ph_d = ph_c;
        if (ph_c == tas_pkg::PH_SCORING)
        begin
            if (cmd == tas_pkg::CMD_RECOVER)
            begin
                ph_d = tas_pkg::PH_RECOVERING;
            end
            else if (near_scr)
            begin
                ph_d = tas_pkg::PH_RELEASING;
            end
        end
        phase_out = ph_d;
        if (ph_d == tas_pkg::PH_RELEASING && (near_rel || cmd == tas_pkg::CMD_RECOVER))
        begin
            phase_out = tas_pkg::PH_RECOVERING;
        end
    end

    // Targets and speed limits of the final phase.
    always_comb
    begin
        lift_tgt  = '0;
        wrist_tgt = '0;
        lift_spd  = '0;
        wrist_spd = '0;
        unique case (phase_out)
            tas_pkg::PH_RECOVERING:
            begin
                lift_tgt  = (wp <= 0) ? acc_lift : rel_lift;
                wrist_tgt = acc_wrist;
                lift_spd  = tas_pkg::LIFT_SPEED;
                wrist_spd = tas_pkg::WRIST_SPEED_FAST;
            end
            tas_pkg::PH_ACCEPTING:
            begin
                lift_tgt  = acc_lift;
                wrist_tgt = acc_wrist;
                lift_spd  = tas_pkg::LIFT_SPEED;
                wrist_spd = tas_pkg::WRIST_SPEED_SLOW;
            end
            tas_pkg::PH_READY:
            begin
                lift_tgt  = acc_lift;
                wrist_tgt = rdy_wrist;
                lift_spd  = tas_pkg::LIFT_SPEED;
                wrist_spd = tas_pkg::WRIST_SPEED_SLOW;
            end
            tas_pkg::PH_SCORING:
            begin
                lift_tgt  = scr_lift;
                wrist_tgt = scr_wrist;
                lift_spd  = tas_pkg::LIFT_SPEED;
                wrist_spd = tas_pkg::WRIST_SPEED_SLOW;
            end
            tas_pkg::PH_RELEASING:
            begin
                lift_tgt  = rel_lift;
                wrist_tgt = (wp <= WRIST_HIGH) ? scr_wrist : rel_wrist;
                lift_spd  = tas_pkg::LIFT_SPEED;
                wrist_spd = tas_pkg::WRIST_SPEED_FAST;
            end
            default:
            begin
                lift_tgt  = '0;
                wrist_tgt = '0;
            end
        endcase
    end

endmodule
`default_nettype wire
